FILE: design/mbprr_pkg.sv
// Shared codes and controller/datapath interface types for the buffer pool and ready ring.
package mbprr_pkg;

    // Request codes
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_PUT   = 2'd2;
    localparam logic [1:0] ACT_GET   = 2'd3;

    // Handle kinds
    localparam logic [1:0] KIND_NULL = 2'd0;
    localparam logic [1:0] KIND_POOL = 2'd1;

    // Result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_FREE     = 3'd1;
    localparam logic [2:0] ST_WRONG_STATE = 3'd2;
    localparam logic [2:0] ST_WRONG_PARAM = 3'd3;
    localparam logic [2:0] ST_NO_READY    = 3'd4;

    localparam logic [7:0] GUARD_VALUE = 8'hDD;

    // Controller to datapath
    typedef struct packed {
        logic       capture;
        logic       set_status;
        logic [2:0] status_code;
        logic       do_free;
        logic       do_bad;
        logic       scan_step;
        logic       load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       kind_null;
        logic       pool;
        logic       full;
        logic       hit;
        logic       last;
    } stat_t;

endpackage

FILE: design/message_buffer_pool_and_ready_ring.sv
// Top level of the message buffer pool allocator with its ready ring.
//
// One request word is taken at a time. Free requests, null or foreign puts and
// allocations with every buffer busy go from accept to decode and then, once the
// output register is free, load it. Allocate, pool puts and gets walk the busy
// flags or the ready ring one slot per cycle from their rotating pointer,
// visiting 1 to BUFFERS slots before the output register is loaded. The result
// word sits in an output register, so the next request is taken while an
// earlier result still waits on m_axis_tready. Busy flags and ready-slot valid
// bits are flip-flops cleared by reset, so no clearing pass is needed; the ring
// index store is a plain memory read only through a valid slot.
module message_buffer_pool_and_ready_ring #(
    parameter int BUFFERS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // buffer_index[3:0], guard_byte[11:4], zero[15:12]
    input  logic [3:0]  s_axis_tuser,   // action[1:0], handle_kind[3:2]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // result_index[3:0], in_use_count[8:4],
                                        // overrun_count[24:9], bad_handle_count[40:25],
                                        // zero[47:41]
    output logic [2:0]  m_axis_tuser    // status[2:0]
);

    mbprr_pkg::cmd_t  cmd;
    mbprr_pkg::stat_t stat;

    logic [2:0]  out_status;
    logic [3:0]  out_result;
    logic [4:0]  out_in_use;
    logic [15:0] out_overrun;
    logic [15:0] out_bad;

    // Sequencer: accept, decode, scan, deliver
    mbprr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Pool state, ring, counters and the output word
    mbprr_dpath #(
        .BUFFERS (BUFFERS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_action   (s_axis_tuser[1:0]),
        .in_kind     (s_axis_tuser[3:2]),
        .in_index    (s_axis_tdata[3:0]),
        .in_guard    (s_axis_tdata[11:4]),
        .cmd         (cmd),
        .stat        (stat),
        .out_status  (out_status),
        .out_result  (out_result),
        .out_in_use  (out_in_use),
        .out_overrun (out_overrun),
        .out_bad     (out_bad)
    );

    // Pack the result word, highest field first
    assign m_axis_tdata = {7'd0, out_bad, out_overrun, out_in_use, out_result};
    assign m_axis_tuser = out_status;

endmodule

FILE: design/mbprr_ctrl.sv
// Request sequencer for the buffer pool and ready ring.
module mbprr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  mbprr_pkg::stat_t  stat,
    output mbprr_pkg::cmd_t   cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.status_code = mbprr_pkg::ST_OK;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.set_status = 1'b1;
                state_next     = S_FINISH;
                case (stat.action)
                    mbprr_pkg::ACT_ALLOC: begin
                        if (stat.full) begin
                            cmd.status_code = mbprr_pkg::ST_NO_FREE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    mbprr_pkg::ACT_FREE: begin
                        if (stat.kind_null) begin
                            cmd.status_code = mbprr_pkg::ST_WRONG_STATE;
                        end else begin
                            cmd.do_free = 1'b1;
                            if (!stat.pool) begin
                                cmd.status_code = mbprr_pkg::ST_WRONG_STATE;
                            end
                        end
                    end
                    mbprr_pkg::ACT_PUT: begin
                        if (stat.kind_null) begin
                            cmd.status_code = mbprr_pkg::ST_WRONG_PARAM;
                        end else if (!stat.pool) begin
                            cmd.do_bad = 1'b1;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                        state_next = S_SCAN;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.hit) begin
                    state_next = S_FINISH;
                end else if (stat.last) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = (stat.action == mbprr_pkg::ACT_GET) ?
                                      mbprr_pkg::ST_NO_READY : mbprr_pkg::ST_WRONG_STATE;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH: begin
                // Hold until the output register can take the word
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: design/mbprr_dpath.sv
// Busy flags, ready ring, pointers, counters and output word for the buffer pool.
module mbprr_dpath #(
    parameter int BUFFERS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        in_action,
    input  logic [1:0]        in_kind,
    input  logic [3:0]        in_index,
    input  logic [7:0]        in_guard,
    input  mbprr_pkg::cmd_t   cmd,
    output mbprr_pkg::stat_t  stat,
    output logic [2:0]        out_status,
    output logic [3:0]        out_result,
    output logic [4:0]        out_in_use,
    output logic [15:0]       out_overrun,
    output logic [15:0]       out_bad
);

    localparam int PW = $clog2(BUFFERS);
    localparam int CW = $clog2(BUFFERS + 1);
    localparam int IW = (PW > 4) ? PW : 4;
    localparam int TW = (CW > 5) ? CW : 5;
    localparam logic [PW-1:0] LAST_POS = PW'(BUFFERS - 1);

    // Captured request
    logic [1:0] action_reg;
    logic [1:0] kind_reg;
    logic [3:0] idx_reg;
    logic [7:0] guard_reg;

    // Working state
    logic           busy_reg [BUFFERS];
    logic           busy_next [BUFFERS];
    logic           rvalid_reg [BUFFERS];
    logic           rvalid_next [BUFFERS];
    logic [3:0]     rmem [BUFFERS];
    logic [3:0]     rd_data_reg;
    logic [PW-1:0]  ap_reg, ap_next;
    logic [PW-1:0]  ip_reg, ip_next;
    logic [PW-1:0]  op_reg, op_next;
    logic [PW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  total_reg, total_next;
    logic [15:0]    overrun_reg, overrun_next;
    logic [15:0]    bad_reg, bad_next;
    logic [2:0]     status_reg, status_next;
    logic [3:0]     result_reg, result_next;
    logic           from_mem_reg, from_mem_next;

    logic [IW-1:0]  idx_wide;
    logic [IW-1:0]  ap_wide;
    logic [TW-1:0]  total_wide;
    logic [PW-1:0]  idx_pos;
    logic           pool;
    logic           hit;
    logic           put_write;

    assign idx_wide   = IW'(idx_reg);
    assign idx_pos    = idx_wide[PW-1:0];
    assign ap_wide    = IW'(ap_reg);
    assign total_wide = TW'(total_reg);
    assign pool       = (kind_reg == mbprr_pkg::KIND_POOL) && (32'(idx_reg) < BUFFERS);

    always_comb begin
        case (action_reg)
            mbprr_pkg::ACT_ALLOC: hit = !busy_reg[ap_reg];
            mbprr_pkg::ACT_PUT:   hit = !rvalid_reg[ip_reg];
            mbprr_pkg::ACT_GET:   hit = rvalid_reg[op_reg];
            default:              hit = 1'b0;
        endcase
    end

    assign stat.action    = action_reg;
    assign stat.kind_null = (kind_reg == mbprr_pkg::KIND_NULL);
    assign stat.pool      = pool;
    assign stat.full      = (total_reg >= CW'(BUFFERS));
    assign stat.hit       = hit;
    assign stat.last      = (cnt_reg == LAST_POS);

    assign put_write = cmd.scan_step && hit && (action_reg == mbprr_pkg::ACT_PUT);

    always_comb begin
        busy_next     = busy_reg;
        rvalid_next   = rvalid_reg;
        ap_next       = ap_reg;
        ip_next       = ip_reg;
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        total_next    = total_reg;
        overrun_next  = overrun_reg;
        bad_next      = bad_reg;
        status_next   = status_reg;
        result_next   = result_reg;
        from_mem_next = from_mem_reg;

        if (cmd.capture) begin
            cnt_next      = '0;
            result_next   = '0;
            from_mem_next = 1'b0;
        end
        if (cmd.set_status) begin
            status_next = cmd.status_code;
        end
        if (cmd.do_free) begin
            if (guard_reg != mbprr_pkg::GUARD_VALUE) begin
                overrun_next = overrun_reg + 16'd1;
            end
            // Freeing a free buffer leaves the count alone
            if (pool && busy_reg[idx_pos]) begin
                busy_next[idx_pos] = 1'b0;
                if (total_reg != '0) begin
                    total_next = total_reg - CW'(1);
                end
            end
        end
        if (cmd.do_bad) begin
            bad_next = bad_reg + 16'd1;
        end
        if (cmd.scan_step) begin
            if (hit) begin
                case (action_reg)
                    mbprr_pkg::ACT_ALLOC: begin
                        busy_next[ap_reg] = 1'b1;
                        total_next        = total_reg + CW'(1);
                        result_next       = ap_wide[3:0];
                    end
                    mbprr_pkg::ACT_PUT: begin
                        rvalid_next[ip_reg] = 1'b1;
                    end
                    mbprr_pkg::ACT_GET: begin
                        rvalid_next[op_reg] = 1'b0;
                        from_mem_next       = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end else begin
                // Advance the active pointer; after a full lap it is back at its start
                cnt_next = cnt_reg + PW'(1);
                case (action_reg)
                    mbprr_pkg::ACT_ALLOC:
                        ap_next = (ap_reg == LAST_POS) ? '0 : ap_reg + PW'(1);
                    mbprr_pkg::ACT_PUT:
                        ip_next = (ip_reg == LAST_POS) ? '0 : ip_reg + PW'(1);
                    mbprr_pkg::ACT_GET:
                        op_next = (op_reg == LAST_POS) ? '0 : op_reg + PW'(1);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BUFFERS; i++) begin
                busy_reg[i]   <= 1'b0;
                rvalid_reg[i] <= 1'b0;
            end
            ap_reg       <= '0;
            ip_reg       <= '0;
            op_reg       <= '0;
            cnt_reg      <= '0;
            total_reg    <= '0;
            overrun_reg  <= '0;
            bad_reg      <= '0;
            status_reg   <= mbprr_pkg::ST_OK;
            result_reg   <= '0;
            from_mem_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            rvalid_reg   <= rvalid_next;
            ap_reg       <= ap_next;
            ip_reg       <= ip_next;
            op_reg       <= op_next;
            cnt_reg      <= cnt_next;
            total_reg    <= total_next;
            overrun_reg  <= overrun_next;
            bad_reg      <= bad_next;
            status_reg   <= status_next;
            result_reg   <= result_next;
            from_mem_reg <= from_mem_next;
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= in_action;
            kind_reg   <= in_kind;
            idx_reg    <= in_index;
            guard_reg  <= in_guard;
        end
    end

    // Ready ring index store; read follows the get pointer
    always_ff @(posedge aclk) begin
        if (put_write) begin
            rmem[ip_reg] <= idx_reg;
        end
        rd_data_reg <= rmem[op_reg];
    end

    // Output word
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status  <= status_reg;
            out_result  <= from_mem_reg ? rd_data_reg : result_reg;
            out_in_use  <= total_wide[4:0];
            out_overrun <= overrun_reg;
            out_bad     <= bad_reg;
        end
    end

endmodule
